/* hdl/efwq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efwq_pkg
// Types, codes and helpers shared by the event flag block and its cells.
// ----------------------------------------------------------------------------
package efwq_pkg;

	localparam int FLAG_BITS   = 32;
	localparam int MAX_WAITERS = 16;

	typedef enum logic [2:0] {
		OP_SET    = 3'd0,
		OP_CLEAR  = 3'd1,
		OP_POLL   = 3'd2,
		OP_WAIT   = 3'd3,
		OP_CANCEL = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_MULTIPLE = 3'd1,
		ST_UNMET    = 3'd2,
		ST_RELEASED = 3'd3,
		ST_QUEUED   = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]           op;
		logic [FLAG_BITS-1:0] pattern;
		logic                 mode_or;
		logic                 clear_all;
		logic                 clear_matched;
		logic [7:0]           waiter_id;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [7:0]           released_id;
		logic [FLAG_BITS-1:0] pattern_snapshot;
		logic [4:0]           waiter_count;
		logic                 last;
	} rsp_t;

	typedef struct packed {
		logic [FLAG_BITS-1:0] want;
		logic                 mode_or;
		logic                 clear_all;
		logic                 clear_matched;
		logic [7:0]           ident;
	} waiter_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	function automatic logic cond_holds(input logic [FLAG_BITS-1:0] flag,
			input logic [FLAG_BITS-1:0] want, input logic mode_or);
		logic [FLAG_BITS-1:0] hit;
		hit = flag & want;
		return mode_or ? (hit != '0) : (hit == want);
	endfunction

	function automatic logic [FLAG_BITS-1:0] apply_clear(input logic [FLAG_BITS-1:0] flag,
			input logic [FLAG_BITS-1:0] want, input logic clr_all, input logic clr_match);
		logic [FLAG_BITS-1:0] r;
		if (clr_all) begin
			r = '0;
		end else if (clr_match) begin
			r = flag & ~want;
		end else begin
			r = flag;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/event_flag_with_waiter_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// event_flag_with_waiter_queue
// Event flag group with an ordered row of waiter cells.
// ----------------------------------------------------------------------------
// Set, clear, poll, wait and cancel each take one request. All but a set
// that walks the row answer in the cycle after acceptance. A set with a
// nonzero pattern that finds waiters queued walks the row of waiter cells
// one entry per cycle, head first: the whole row shifts toward the head, a
// released waiter leaves with one result, a kept waiter goes back in behind
// the others, and one result per released waiter comes before the final
// result. Output stalls hold the walk. No request is taken during a walk.
module event_flag_with_waiter_queue #(
	parameter int MAX_WAITERS = efwq_pkg::MAX_WAITERS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire efwq_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output efwq_pkg::rsp_t      out_data,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata
);
	localparam int CW = $clog2(MAX_WAITERS + 1);
	localparam int FB = efwq_pkg::FLAG_BITS;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t               state_q;
	logic                 allow_q;
	logic [FB-1:0]        flag_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rem_q;
	logic                 out_valid_q;
	efwq_pkg::rsp_t       out_q;

	efwq_pkg::waiter_t    cell_d [MAX_WAITERS];
	efwq_pkg::cell_ctl_t  cell_ctl [MAX_WAITERS];
	efwq_pkg::waiter_t    load_d;
	efwq_pkg::waiter_t    head;
	efwq_pkg::waiter_t    new_w;

	logic                 out_free, accept, blocked, cond_in, match, step;
	logic                 push, keep;
	logic                 emit;
	efwq_pkg::rsp_t       emit_d;
	logic [FB-1:0]        set_flag;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == S_IDLE && out_free);
	assign accept   = in_valid && !in_stall;
	assign blocked  = !allow_q && (count_q != '0);
	assign cond_in  = efwq_pkg::cond_holds(flag_q, in_data.pattern, in_data.mode_or);
	assign set_flag = flag_q | in_data.pattern;
	assign head     = cell_d[0];
	assign match    = (flag_q != '0) && efwq_pkg::cond_holds(flag_q, head.want, head.mode_or);
	assign step     = (state_q == S_WALK) && out_free;
	assign keep     = step && !match;
	assign push     = accept && (in_data.op == efwq_pkg::OP_WAIT) && !blocked && !cond_in
		&& (count_q < CW'(MAX_WAITERS));

	always_comb begin
		new_w.want          = in_data.pattern;
		new_w.mode_or       = in_data.mode_or;
		new_w.clear_all     = in_data.clear_all;
		new_w.clear_matched = in_data.clear_matched;
		new_w.ident         = in_data.waiter_id;
		load_d = (state_q == S_WALK) ? head : new_w;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_WAITERS; gi++) begin : g_cell
			always_comb begin
				cell_ctl[gi].shift = step;
				cell_ctl[gi].load  = (keep && (count_q - CW'(1) == CW'(gi)))
					|| (push && (count_q == CW'(gi)));
			end
			efwq_cell u_cell (
				.clk    (clk),
				.ctl    (cell_ctl[gi]),
				.load_d (load_d),
				.next_d ((gi == MAX_WAITERS - 1) ? load_d : cell_d[(gi + 1) % MAX_WAITERS]),
				.d      (cell_d[gi])
			);
		end
	endgenerate

	// result of the current cycle
	always_comb begin
		emit = 1'b0;
		emit_d.status           = efwq_pkg::ST_OK;
		emit_d.released_id      = '0;
		emit_d.pattern_snapshot = flag_q;
		emit_d.waiter_count     = 5'(count_q);
		emit_d.last             = 1'b1;
		if (accept) begin
			emit = 1'b1;
			unique case (in_data.op)
				efwq_pkg::OP_SET: begin
					emit = !((in_data.pattern != '0) && (count_q != '0));
					emit_d.pattern_snapshot = set_flag;
				end
				efwq_pkg::OP_CLEAR: begin
					emit_d.pattern_snapshot = flag_q & in_data.pattern;
				end
				efwq_pkg::OP_POLL, efwq_pkg::OP_WAIT: begin
					if (blocked) begin
						emit_d.status = efwq_pkg::ST_MULTIPLE;
					end else if (cond_in) begin
						emit_d.status = efwq_pkg::ST_OK;
					end else if (in_data.op == efwq_pkg::OP_POLL) begin
						emit_d.status = efwq_pkg::ST_UNMET;
					end else if (push) begin
						emit_d.status       = efwq_pkg::ST_QUEUED;
						emit_d.released_id  = in_data.waiter_id;
						emit_d.waiter_count = 5'(count_q + CW'(1));
					end else begin
						emit_d.status = efwq_pkg::ST_FULL;
					end
				end
				efwq_pkg::OP_CANCEL: begin
					emit_d.pattern_snapshot = in_data.pattern;
				end
				default: begin
				end
			endcase
		end else if (step && match) begin
			emit = 1'b1;
			emit_d.status       = efwq_pkg::ST_RELEASED;
			emit_d.released_id  = head.ident;
			emit_d.waiter_count = 5'(count_q - CW'(1));
			emit_d.last         = 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			allow_q     <= 1'b0;
			flag_q      <= '0;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				allow_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_data.op)
							efwq_pkg::OP_SET: begin
								flag_q <= set_flag;
								if ((in_data.pattern != '0) && (count_q != '0)) begin
									rem_q   <= count_q;
									state_q <= S_WALK;
								end
							end
							efwq_pkg::OP_CLEAR: flag_q <= flag_q & in_data.pattern;
							efwq_pkg::OP_POLL, efwq_pkg::OP_WAIT: begin
								if (!blocked && cond_in) begin
									flag_q <= efwq_pkg::apply_clear(flag_q, in_data.pattern,
										in_data.clear_all, in_data.clear_matched);
								end else if (push) begin
									count_q <= count_q + CW'(1);
								end
							end
							efwq_pkg::OP_CANCEL: begin
								flag_q  <= in_data.pattern;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (step) begin
						if (match) begin
							flag_q  <= efwq_pkg::apply_clear(flag_q, head.want,
								head.clear_all, head.clear_matched);
							count_q <= count_q - CW'(1);
						end
						rem_q <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WAITERS))
		else $error("waiter count beyond depth");
	a_release_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == efwq_pkg::ST_RELEASED) |-> !out_q.last)
		else $error("release result marked last");
	a_walk_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("request taken during walk");
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && rem_q == CW'(1)) |=> (state_q == S_FIN))
		else $error("walk did not finish");
`endif

endmodule
`default_nettype wire

/* hdl/efwq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efwq_cell
// One waiter slot: takes its neighbour's entry on shift, or the load entry (new or kept) on load; load wins.
// ----------------------------------------------------------------------------
module efwq_cell (
	input  wire logic               clk,
	input  wire efwq_pkg::cell_ctl_t ctl,
	input  wire efwq_pkg::waiter_t  load_d,
	input  wire efwq_pkg::waiter_t  next_d,
	output efwq_pkg::waiter_t       d
);
	efwq_pkg::waiter_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_d;
		end else if (ctl.shift) begin
			entry_q <= next_d;
		end
	end

	assign d = entry_q;
endmodule
`default_nettype wire

/* bench/efwq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efwq_checker
// Watches the request, result and register ports of the event flag block,
// keeps its own flag, waiter table and mode, works out the results of every
// accepted request and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module efwq_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_stall,
	input  wire efwq_pkg::req_t in_data,
	input  wire logic           out_valid,
	input  wire logic           out_stall,
	input  wire efwq_pkg::rsp_t out_data,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata,
	output int                  errors,
	output int                  pending
);
	logic                           multi_ok;
	logic [efwq_pkg::FLAG_BITS-1:0] flag;
	int                             nq;
	efwq_pkg::waiter_t              tbl[efwq_pkg::MAX_WAITERS];
	efwq_pkg::rsp_t                 due[$];

	assign pending = due.size();

	function automatic logic satisfied(logic [efwq_pkg::FLAG_BITS-1:0] f,
			logic [efwq_pkg::FLAG_BITS-1:0] w, logic any);
		if (any) begin
			return (f & w) != 0;
		end
		return (f & w) == w;
	endfunction

	function automatic logic [efwq_pkg::FLAG_BITS-1:0] after_clear(
			logic [efwq_pkg::FLAG_BITS-1:0] f, logic [efwq_pkg::FLAG_BITS-1:0] w,
			logic all, logic matched);
		if (all) begin
			return '0;
		end
		if (matched) begin
			return f & ~w;
		end
		return f;
	endfunction

	function automatic void owe(efwq_pkg::status_t st, logic [7:0] id,
			logic [efwq_pkg::FLAG_BITS-1:0] snap, int cnt, logic fin);
		efwq_pkg::rsp_t e;
		e.status = st;
		e.released_id = id;
		e.pattern_snapshot = snap;
		e.waiter_count = 5'(cnt);
		e.last = fin;
		due.push_back(e);
	endfunction

	function automatic void flag_request(efwq_pkg::req_t r);
		logic                           blocked;
		logic [efwq_pkg::FLAG_BITS-1:0] snap;
		int                             kept;
		int                             left;
		efwq_pkg::waiter_t              w;
		blocked = !multi_ok && nq > 0;
		case (r.op)
			efwq_pkg::OP_SET: begin
				if (r.pattern != 0) begin
					flag |= r.pattern;
					kept = 0;
					left = nq;
					for (int i = 0; i < nq; i++) begin
						w = tbl[i];
						if (flag != 0 && satisfied(flag, w.want, w.mode_or)) begin
							snap = flag;
							flag = after_clear(flag, w.want, w.clear_all, w.clear_matched);
							left--;
							owe(efwq_pkg::ST_RELEASED, w.ident, snap, left, 1'b0);
						end else begin
							tbl[kept] = w;
							kept++;
						end
					end
					nq = kept;
				end
				owe(efwq_pkg::ST_OK, 8'd0, flag, nq, 1'b1);
			end
			efwq_pkg::OP_CLEAR: begin
				flag &= r.pattern;
				owe(efwq_pkg::ST_OK, 8'd0, flag, nq, 1'b1);
			end
			efwq_pkg::OP_POLL, efwq_pkg::OP_WAIT: begin
				if (blocked) begin
					owe(efwq_pkg::ST_MULTIPLE, 8'd0, flag, nq, 1'b1);
				end else if (satisfied(flag, r.pattern, r.mode_or)) begin
					snap = flag;
					flag = after_clear(flag, r.pattern, r.clear_all, r.clear_matched);
					owe(efwq_pkg::ST_OK, 8'd0, snap, nq, 1'b1);
				end else if (r.op == efwq_pkg::OP_POLL) begin
					owe(efwq_pkg::ST_UNMET, 8'd0, flag, nq, 1'b1);
				end else if (nq >= efwq_pkg::MAX_WAITERS) begin
					owe(efwq_pkg::ST_FULL, 8'd0, flag, nq, 1'b1);
				end else begin
					tbl[nq] = '{want: r.pattern, mode_or: r.mode_or, clear_all: r.clear_all,
						clear_matched: r.clear_matched, ident: r.waiter_id};
					nq++;
					owe(efwq_pkg::ST_QUEUED, r.waiter_id, flag, nq, 1'b1);
				end
			end
			efwq_pkg::OP_CANCEL: begin
				owe(efwq_pkg::ST_OK, 8'd0, r.pattern, nq, 1'b1);
				nq = 0;
				flag = r.pattern;
			end
			default: begin
				owe(efwq_pkg::ST_OK, 8'd0, flag, nq, 1'b1);
			end
		endcase
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch in %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		efwq_pkg::rsp_t e;
		if (!arst_n) begin
			multi_ok = 1'b0;
			flag = '0;
			nq = 0;
			errors = 0;
			due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (due.size() == 0) begin
					report("unexpected result", 32'(out_data.status), 32'd0);
				end else begin
					e = due.pop_front();
					if (out_data.status !== e.status)
						report("status", 32'(out_data.status), 32'(e.status));
					if (out_data.released_id !== e.released_id)
						report("released_id", 32'(out_data.released_id),
							32'(e.released_id));
					if (out_data.pattern_snapshot !== e.pattern_snapshot)
						report("pattern_snapshot", out_data.pattern_snapshot,
							e.pattern_snapshot);
					if (out_data.waiter_count !== e.waiter_count)
						report("waiter_count", 32'(out_data.waiter_count),
							32'(e.waiter_count));
					if (out_data.last !== e.last)
						report("last", 32'(out_data.last), 32'(e.last));
				end
			end
			if (in_valid && !in_stall) begin
				flag_request(in_data);
			end
			if (cfg_we) begin
				multi_ok = cfg_wdata;
			end
		end
	end

endmodule
`default_nettype wire

/* bench/tb_event_flag_with_waiter_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_event_flag_with_waiter_queue
// Drives the event flag block with directed and random flag requests under
// varying idle and stall rates and a long result hold-off, while the checker
// beside it predicts and compares every result; prints the verdict.
// ----------------------------------------------------------------------------
module tb_event_flag_with_waiter_queue;

	localparam int IDLE_LIMIT = 20000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	efwq_pkg::req_t in_data = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	efwq_pkg::rsp_t out_data;
	logic           cfg_we = 1'b0;
	logic           cfg_wdata = 1'b0;
	int             errors;
	int             pending;
	int             idle_pct = 0;
	int             stall_pct = 0;
	int             hold_left = 0;
	int             quiet = 0;

	always #6 clk = ~clk;

	event_flag_with_waiter_queue dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	efwq_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	// receiver side, with the long hold-off counted here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= $urandom_range(99) < stall_pct;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= IDLE_LIMIT) begin
			$display("tb_event_flag_with_waiter_queue NOT OK");
			$finish;
		end
	end

	task automatic send(logic [2:0] op, logic [31:0] pat, logic any, logic all,
			logic matched, logic [7:0] id);
		efwq_pkg::req_t r;
		r.op = op;
		r.pattern = pat;
		r.mode_or = any;
		r.clear_all = all;
		r.clear_matched = matched;
		r.waiter_id = id;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_mode(logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] few_bits();
		logic [31:0] v;
		v = 32'd1 << $urandom_range(31);
		if ($urandom_range(1)) v |= 32'd1 << $urandom_range(31);
		return v;
	endfunction

	task automatic random_request();
		int          pick;
		logic [2:0]  op;
		logic [31:0] pat;
		pick = $urandom_range(99);
		pat = $urandom_range(3) == 0 ? $urandom() : few_bits();
		if (pick < 33) op = efwq_pkg::OP_WAIT;
		else if (pick < 60) op = efwq_pkg::OP_SET;
		else if (pick < 70) op = efwq_pkg::OP_CLEAR;
		else if (pick < 84) op = efwq_pkg::OP_POLL;
		else if (pick < 92) op = efwq_pkg::OP_CANCEL;
		else op = 3'($urandom_range(7, 5));
		if (op == efwq_pkg::OP_CLEAR) pat = ~pat;
		if (op == efwq_pkg::OP_CANCEL && $urandom_range(1)) pat = '0;
		if ($urandom_range(15) == 0) pat = '0;
		send(op, pat, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-waiter mode: rejections while a waiter is queued
		write_mode(1'b0);
		send(efwq_pkg::OP_SET, 32'h0, 1'b0, 1'b0, 1'b0, 8'h00);
		send(efwq_pkg::OP_WAIT, 32'h0, 1'b1, 1'b0, 1'b0, 8'h11);
		send(efwq_pkg::OP_WAIT, 32'h0, 1'b0, 1'b0, 1'b0, 8'h12);
		send(efwq_pkg::OP_WAIT, 32'h8000_0001, 1'b0, 1'b0, 1'b1, 8'hff);
		send(efwq_pkg::OP_POLL, 32'h1, 1'b1, 1'b0, 1'b0, 8'h00);
		send(efwq_pkg::OP_WAIT, 32'h2, 1'b1, 1'b0, 1'b0, 8'h01);
		send(efwq_pkg::OP_SET, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 8'h00);
		send(efwq_pkg::OP_POLL, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 8'h00);
		send(3'd5, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 8'hff);
		send(3'd7, 32'h0, 1'b0, 1'b0, 1'b0, 8'h00);
		settle();

		// many waiters: fill to the brim, overflow, then one set releases in turn
		write_mode(1'b1);
		send(efwq_pkg::OP_CANCEL, 32'h0, 1'b0, 1'b0, 1'b0, 8'h00);
		for (int i = 0; i < efwq_pkg::MAX_WAITERS + 1; i++)
			send(efwq_pkg::OP_WAIT, 32'd1 << i, i[0], i[1], i[2], 8'(8'hf0 - i));
		send(efwq_pkg::OP_CLEAR, 32'hffff_ffff, 1'b0, 1'b0, 1'b0, 8'h00);
		send(efwq_pkg::OP_SET, 32'hffff_ffff, 1'b0, 1'b0, 1'b0, 8'h00);
		send(efwq_pkg::OP_CANCEL, 32'hffff_ffff, 1'b0, 1'b0, 1'b0, 8'h00);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = ph == 1 || ph == 3 ? (ph == 1 ? 73 : 33) : 0;
			stall_pct = ph == 2 ? 73 : (ph == 3 ? 33 : 0);
			write_mode(ph == 2 ? 1'b0 : 1'b1);
			if (ph == 0) hold_left <= 300;
			for (int n = 0; n < 32; n++) random_request();
			settle();
		end

		settle();
		if (errors == 0 && pending == 0) begin
			$display("tb_event_flag_with_waiter_queue OK");
		end else begin
			$display("tb_event_flag_with_waiter_queue NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
hdl/efwq_pkg.sv
hdl/efwq_cell.sv
hdl/event_flag_with_waiter_queue.sv
bench/efwq_checker.sv
bench/tb_event_flag_with_waiter_queue.sv
